@@ hdl/slcan_pkg.sv @@
`default_nettype none

package slcan_pkg;

  localparam int MAX_DATA_BYTES_DEF = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_STD_DATA = 8'h74;
  localparam logic [7:0] CH_EXT_DATA = 8'h54;
  localparam logic [7:0] CH_STD_RTR = 8'h72;
  localparam logic [7:0] CH_EXT_RTR = 8'h52;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_LC_A = 8'h61;
  localparam logic [7:0] CH_LC_F = 8'h66;
  localparam logic [7:0] CH_UC_A = 8'h41;
  localparam logic [7:0] CH_UC_F = 8'h46;

  localparam logic [1:0] KIND_STD_DATA = 2'd0;
  localparam logic [1:0] KIND_EXT_DATA = 2'd1;
  localparam logic [1:0] KIND_STD_RTR = 2'd2;
  localparam logic [1:0] KIND_EXT_RTR = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_BAD_CMD = 2'd2;
  localparam logic [1:0] ST_BAD_DIGIT = 2'd3;

  typedef struct packed {
    logic       is_cr;
    logic       cmd_ok;
    logic [1:0] kind;
    logic       hex_ok;
    logic [3:0] hex_val;
  } char_class_t;

endpackage

`default_nettype wire

@@ hdl/slcan_ifs.sv @@
`default_nettype none

interface slcan_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface slcan_tx_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        extended;
  logic        remote;
  logic [31:0] frame_id;
  logic [3:0]  dlc;
  logic [63:0] payload;
  modport source (output valid, output status, output extended, output remote,
                  output frame_id, output dlc, output payload, input ready);
  modport sink (input valid, input status, input extended, input remote,
                input frame_id, input dlc, input payload, output ready);
endinterface

`default_nettype wire

@@ hdl/slcan_ascii_frame_decoder_core.sv @@
// slcan ascii frame decoder
// rx carries one ascii character per transfer (valid/ready); a carriage
// return closes the line and produces exactly one transfer on tx with
// status, extended, remote, frame_id, dlc and payload. other characters
// produce nothing on tx.
// throughput: one character per cycle while the queue has room, set by the
// combinational classify stage and the line state update in the back end.
// a result passes through the two-entry queue and then the output register
// before it is valid on tx.
// rx.ready is high whenever the queue has room; when tx stalls, a pending
// result holds in the output register, ordinary characters keep being
// consumed, and only a following carriage return waits in the queue, so
// rx backs up after two more characters.
// reset (rst, synchronous, active high) empties the queue, clears tx.valid
// and starts a fresh line.
`default_nettype none

module slcan_ascii_frame_decoder_core #(
  parameter int MAX_DATA_BYTES = slcan_pkg::MAX_DATA_BYTES_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  slcan_rx_if.sink   rx,
  slcan_tx_if.source tx
);

  logic                   push;
  logic                   full;
  logic                   pop;
  logic                   not_empty;
  slcan_pkg::char_class_t push_data;
  slcan_pkg::char_class_t pop_data;

  slcan_front u_front (
    .rx        (rx),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  slcan_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_data  (pop_data)
  );

  slcan_back #(
    .MAX_DATA_BYTES (MAX_DATA_BYTES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (not_empty),
    .q_data  (pop_data),
    .q_pop   (pop),
    .tx      (tx)
  );

endmodule

`default_nettype wire

@@ hdl/slcan_front.sv @@
`default_nettype none

module slcan_front (
  slcan_rx_if.sink               rx,
  input  wire logic              full,
  output logic                   push,
  output slcan_pkg::char_class_t push_data
);

  logic [7:0] c;

  assign c = rx.ch;
  assign rx.ready = !full;
  assign push = rx.valid && !full;

  always_comb begin
    push_data = '0;
    push_data.is_cr = (c == slcan_pkg::CH_CR);
    push_data.cmd_ok = 1'b1;
    case (c)
      slcan_pkg::CH_STD_DATA: push_data.kind = slcan_pkg::KIND_STD_DATA;
      slcan_pkg::CH_EXT_DATA: push_data.kind = slcan_pkg::KIND_EXT_DATA;
      slcan_pkg::CH_STD_RTR:  push_data.kind = slcan_pkg::KIND_STD_RTR;
      slcan_pkg::CH_EXT_RTR:  push_data.kind = slcan_pkg::KIND_EXT_RTR;
      default: begin
        push_data.kind = slcan_pkg::KIND_STD_DATA;
        push_data.cmd_ok = 1'b0;
      end
    endcase
    if (c inside {[slcan_pkg::CH_ZERO:slcan_pkg::CH_NINE]}) begin
      push_data.hex_ok = 1'b1;
      push_data.hex_val = 4'(c - slcan_pkg::CH_ZERO);
    end else if (c inside {[slcan_pkg::CH_LC_A:slcan_pkg::CH_LC_F]}) begin
      push_data.hex_ok = 1'b1;
      push_data.hex_val = 4'(c - slcan_pkg::CH_LC_A + 8'd10);
    end else if (c inside {[slcan_pkg::CH_UC_A:slcan_pkg::CH_UC_F]}) begin
      push_data.hex_ok = 1'b1;
      push_data.hex_val = 4'(c - slcan_pkg::CH_UC_A + 8'd10);
    end
  end

endmodule

`default_nettype wire

@@ hdl/slcan_queue.sv @@
`default_nettype none

module slcan_queue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire slcan_pkg::char_class_t push_data,
  output logic                        full,
  input  wire logic                   pop,
  output logic                        not_empty,
  output slcan_pkg::char_class_t      pop_data
);

  localparam int DEPTH = slcan_pkg::QUEUE_DEPTH;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  slcan_pkg::char_class_t entries [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;

  assign full = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/slcan_back.sv @@
`default_nettype none

module slcan_back #(
  parameter int MAX_DATA_BYTES = slcan_pkg::MAX_DATA_BYTES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   q_valid,
  input  wire slcan_pkg::char_class_t q_data,
  output logic                        q_pop,
  slcan_tx_if.source                  tx
);

  localparam int DATA_W = 8 * MAX_DATA_BYTES;
  localparam int NIB = 2 * MAX_DATA_BYTES;
  localparam logic [4:0] MAX_V = 5'(MAX_DATA_BYTES);

  logic [4:0]        pos, pos_next;
  logic [1:0]        kind, kind_next;
  logic [31:0]       id_acc, id_acc_next;
  logic [3:0]        lc, lc_next;
  logic [DATA_W-1:0] data, data_next;
  logic [1:0]        err, err_next;

  logic        ext, rem;
  logic [4:0]  idlen, hdr, d, nib;
  logic [5:0]  need;
  logic [1:0]  st;
  logic [63:0] payload_w;
  logic        emit;

  assign q_pop = q_valid && (!q_data.is_cr || !tx.valid || tx.ready);
  assign emit = q_pop && q_data.is_cr;

  always_comb begin
    ext = kind[0];
    rem = kind[1];
    idlen = ext ? 5'd8 : 5'd3;
    hdr = idlen + 5'd2;
    d = pos - hdr;
    nib = {d[4:1], ~d[0]};
    need = {1'b0, hdr} + (rem ? 6'd0 : {1'b0, lc, 1'b0});
    st = err;
    if (err == slcan_pkg::ST_OK && (pos == '0 || {1'b0, pos} < need)) begin
      st = slcan_pkg::ST_SHORT;
    end
    payload_w = '0;
    payload_w[DATA_W-1:0] = data;

    pos_next = pos;
    kind_next = kind;
    id_acc_next = id_acc;
    lc_next = lc;
    data_next = data;
    err_next = err;
    if (q_pop) begin
      if (q_data.is_cr) begin
        pos_next = '0;
        kind_next = '0;
        id_acc_next = '0;
        lc_next = '0;
        data_next = '0;
        err_next = slcan_pkg::ST_OK;
      end else begin
        if (err == slcan_pkg::ST_OK) begin
          if (pos == '0) begin
            if (q_data.cmd_ok) begin
              kind_next = q_data.kind;
            end else begin
              err_next = slcan_pkg::ST_BAD_CMD;
            end
          end else if (pos <= idlen) begin
            if (q_data.hex_ok) begin
              id_acc_next = {id_acc[27:0], q_data.hex_val};
            end else begin
              err_next = slcan_pkg::ST_BAD_DIGIT;
            end
          end else if (pos == idlen + 5'd1) begin
            if (q_data.hex_ok && {1'b0, q_data.hex_val} <= MAX_V) begin
              lc_next = q_data.hex_val;
            end else begin
              err_next = slcan_pkg::ST_BAD_DIGIT;
            end
          end else if (!rem && {1'b0, d} < {1'b0, lc, 1'b0}) begin
            if (q_data.hex_ok) begin
              for (int i = 0; i < NIB; i++) begin
                if (nib == 5'(i)) begin
                  data_next[4*i +: 4] = q_data.hex_val;
                end
              end
            end else begin
              err_next = slcan_pkg::ST_BAD_DIGIT;
            end
          end
        end
        if (pos != 5'd31) begin
          pos_next = pos + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      kind <= '0;
      id_acc <= '0;
      lc <= '0;
      data <= '0;
      err <= slcan_pkg::ST_OK;
      tx.valid <= 1'b0;
    end else begin
      pos <= pos_next;
      kind <= kind_next;
      id_acc <= id_acc_next;
      lc <= lc_next;
      data <= data_next;
      err <= err_next;
      if (emit) begin
        tx.valid <= 1'b1;
      end else if (tx.ready) begin
        tx.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      tx.status <= st;
      if (st == slcan_pkg::ST_OK) begin
        tx.extended <= ext;
        tx.remote <= rem;
        tx.frame_id <= id_acc;
        tx.dlc <= lc;
        tx.payload <= rem ? 64'd0 : payload_w;
      end else begin
        tx.extended <= 1'b0;
        tx.remote <= 1'b0;
        tx.frame_id <= '0;
        tx.dlc <= '0;
        tx.payload <= '0;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/slcan_chk.sv @@
`default_nettype none

module slcan_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        tx_valid,
  input wire logic        tx_ready,
  input wire logic [1:0]  status,
  input wire logic        extended,
  input wire logic        remote,
  input wire logic [31:0] frame_id,
  input wire logic [3:0]  dlc,
  input wire logic [63:0] payload
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !tx_valid)
    else $error("tx valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_ready |=> tx_valid && $stable(status) && $stable(frame_id)
      && $stable(payload))
    else $error("stalled result changed");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    tx_valid && status != slcan_pkg::ST_OK |-> !extended && !remote
      && frame_id == 32'd0 && dlc == 4'd0 && payload == 64'd0)
    else $error("error result with nonzero fields");

  a_ok_shape: assert property (@(posedge clk) disable iff (rst)
    tx_valid && status == slcan_pkg::ST_OK |-> dlc <= 4'd8
      && (!remote || payload == 64'd0) && (extended || frame_id[31:12] == 20'd0))
    else $error("ok result out of range");

endmodule

bind slcan_ascii_frame_decoder_core slcan_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .tx_valid (tx.valid),
  .tx_ready (tx.ready),
  .status   (tx.status),
  .extended (tx.extended),
  .remote   (tx.remote),
  .frame_id (tx.frame_id),
  .dlc      (tx.dlc),
  .payload  (tx.payload)
);

`default_nettype wire

@@ bench/slcan_ascii_frame_decoder_core_tb.sv @@
`default_nettype none

module slcan_ascii_frame_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slcan_pkg::*;

  localparam int MAX_BYTES = MAX_DATA_BYTES_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_CHARS = 400;

  typedef struct packed {
    logic [1:0]  status;
    logic        extended;
    logic        remote;
    logic [31:0] frame_id;
    logic [3:0]  dlc;
    logic [63:0] payload;
  } frame_t;

  logic clk;
  logic rst;

  slcan_rx_if rx_ch ();
  slcan_tx_if tx_ch ();

  slcan_ascii_frame_decoder_core #(
    .MAX_DATA_BYTES(MAX_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .rx(rx_ch),
    .tx(tx_ch)
  );

  logic [7:0] char_q[$];
  logic [7:0] line_buf[$];
  frame_t     frames_due[$];

  int send_idle_pct;
  int recv_stall_pct;
  logic hold_tog;
  logic hold_seen;
  int hold_left;
  int mismatches;
  int quiet_cycles;
  int last_idlen;
  int chars_queued;

  // line decoder state
  logic [4:0]  lp_pos;
  logic [1:0]  lp_kind;
  logic [31:0] lp_id;
  logic [3:0]  lp_dlc;
  logic [63:0] lp_data;
  logic [1:0]  lp_err;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // {valid hex, value}
  function automatic logic [4:0] hex_of(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return {1'b1, 4'(c - CH_ZERO)};
    if (c >= CH_LC_A && c <= CH_LC_F) return {1'b1, 4'(c - CH_LC_A + 8'd10)};
    if (c >= CH_UC_A && c <= CH_UC_F) return {1'b1, 4'(c - CH_UC_A + 8'd10)};
    return 5'd0;
  endfunction

  function automatic logic [7:0] hex_char(input int v);
    if (v < 10) return CH_ZERO + 8'(v);
    return ($urandom_range(1) ? CH_UC_A : CH_LC_A) + 8'(v - 10);
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (hex_of(c) != 5'd0 || c == CH_CR);
    return c;
  endfunction

  function automatic logic [7:0] any_but_cr();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == CH_CR);
    return c;
  endfunction

  task automatic clear_line();
    lp_pos = '0;
    lp_kind = KIND_STD_DATA;
    lp_id = '0;
    lp_dlc = '0;
    lp_data = '0;
    lp_err = ST_OK;
  endtask

  task automatic decode_char(input logic [7:0] c);
    logic [4:0] hv;
    int idlen;
    int hdr;
    int need;
    int d;
    int sh;
    frame_t f;
    idlen = lp_kind[0] ? 8 : 3;
    hdr = idlen + 2;
    if (c == CH_CR) begin
      f = '0;
      f.status = lp_err;
      if (lp_err == ST_OK) begin
        need = hdr + (lp_kind[1] ? 0 : 2 * int'(lp_dlc));
        if (lp_pos == 0 || int'(lp_pos) < need) f.status = ST_SHORT;
      end
      if (f.status == ST_OK) begin
        f.extended = lp_kind[0];
        f.remote = lp_kind[1];
        f.frame_id = lp_id;
        f.dlc = lp_dlc;
        f.payload = lp_kind[1] ? 64'd0 : lp_data;
      end
      frames_due.push_back(f);
      clear_line();
    end else begin
      if (lp_err == ST_OK) begin
        hv = hex_of(c);
        if (lp_pos == 0) begin
          case (c)
            CH_STD_DATA: lp_kind = KIND_STD_DATA;
            CH_EXT_DATA: lp_kind = KIND_EXT_DATA;
            CH_STD_RTR: lp_kind = KIND_STD_RTR;
            CH_EXT_RTR: lp_kind = KIND_EXT_RTR;
            default: lp_err = ST_BAD_CMD;
          endcase
        end else if (int'(lp_pos) <= idlen) begin
          if (hv[4]) lp_id = {lp_id[27:0], hv[3:0]};
          else lp_err = ST_BAD_DIGIT;
        end else if (int'(lp_pos) == idlen + 1) begin
          if (hv[4] && int'(hv[3:0]) <= MAX_BYTES) lp_dlc = hv[3:0];
          else lp_err = ST_BAD_DIGIT;
        end else if (!lp_kind[1]) begin
          d = int'(lp_pos) - hdr;
          if (d < 2 * int'(lp_dlc)) begin
            if (hv[4]) begin
              sh = 8 * (d / 2) + ((d % 2 == 0) ? 4 : 0);
              lp_data = lp_data | (64'(hv[3:0]) << sh);
            end else begin
              lp_err = ST_BAD_DIGIT;
            end
          end
        end
      end
      if (lp_pos != 5'd31) lp_pos = lp_pos + 5'd1;
    end
  endtask

  // character driver
  always @(posedge clk) begin
    if (rst) begin
      rx_ch.valid <= 1'b0;
      rx_ch.ch <= '0;
    end else if (!rx_ch.valid || rx_ch.ready) begin
      if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        rx_ch.valid <= 1'b1;
        rx_ch.ch <= char_q.pop_front();
      end else begin
        rx_ch.valid <= 1'b0;
      end
    end
  end

  // result sink, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      tx_ch.ready <= 1'b0;
      hold_seen <= 1'b0;
      hold_left <= 0;
    end else if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= HOLD_CYCLES;
      tx_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      tx_ch.ready <= 1'b0;
    end else begin
      tx_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // prediction on each character transfer, check on each result transfer
  always @(posedge clk) begin
    frame_t got;
    frame_t want;
    if (rst) begin
      clear_line();
    end else begin
      if (rx_ch.valid && rx_ch.ready) decode_char(rx_ch.ch);
      if (tx_ch.valid && tx_ch.ready) begin
        got = '{tx_ch.status, tx_ch.extended, tx_ch.remote, tx_ch.frame_id,
                tx_ch.dlc, tx_ch.payload};
        if (frames_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status %0d ext %0d rem %0d id %h dlc %0d data %h",
                     got.status, got.extended, got.remote, got.frame_id, got.dlc,
                     got.payload);
        end else begin
          want = frames_due.pop_front();
          if (got.status !== want.status || got.extended !== want.extended ||
              got.remote !== want.remote || got.frame_id !== want.frame_id ||
              got.dlc !== want.dlc || got.payload !== want.payload) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch expected: status %0d ext %0d rem %0d id %h dlc %0d data %h",
                       want.status, want.extended, want.remote, want.frame_id, want.dlc,
                       want.payload);
              $display("         actual:   status %0d ext %0d rem %0d id %h dlc %0d data %h",
                       got.status, got.extended, got.remote, got.frame_id, got.dlc,
                       got.payload);
            end
          end
        end
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("slcan_ascii_frame_decoder_core_tb: FAIL");
        $finish;
      end
    end
  end

  task automatic flush_line();
    foreach (line_buf[i]) char_q.push_back(line_buf[i]);
    char_q.push_back(CH_CR);
    chars_queued += line_buf.size() + 1;
    line_buf.delete();
  endtask

  task automatic push_text(input string s);
    line_buf.delete();
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    flush_line();
  endtask

  task automatic build_frame();
    logic [1:0] kind;
    int dlc;
    int digit_mode;
    int r;
    line_buf.delete();
    kind = 2'($urandom_range(3));
    case (kind)
      KIND_STD_DATA: line_buf.push_back(CH_STD_DATA);
      KIND_EXT_DATA: line_buf.push_back(CH_EXT_DATA);
      KIND_STD_RTR: line_buf.push_back(CH_STD_RTR);
      default: line_buf.push_back(CH_EXT_RTR);
    endcase
    last_idlen = kind[0] ? 8 : 3;
    digit_mode = $urandom_range(9);
    for (int i = 0; i < last_idlen; i++)
      line_buf.push_back(hex_char(digit_mode == 0 ? 0 : digit_mode == 1 ? 15 :
                                  $urandom_range(15)));
    dlc = ($urandom_range(4) == 0) ? MAX_BYTES : $urandom_range(MAX_BYTES);
    line_buf.push_back(hex_char(dlc));
    if (!kind[1])
      for (int i = 0; i < 2 * dlc; i++)
        line_buf.push_back(hex_char(digit_mode == 0 ? 0 : digit_mode == 1 ? 15 :
                                    $urandom_range(15)));
    r = $urandom_range(9);
    if (r < 2) repeat ($urandom_range(1, 4)) line_buf.push_back(any_but_cr());
    else if (r == 2) repeat ($urandom_range(10, 30)) line_buf.push_back(any_but_cr());
  endtask

  task automatic add_line();
    int r;
    int n;
    r = $urandom_range(99);
    build_frame();
    if (r < 65) begin
    end else if (r < 72) begin
      n = $urandom_range(line_buf.size() - 1);
      while (line_buf.size() > n) void'(line_buf.pop_back());
    end else if (r < 80) begin
      n = $urandom_range(1, line_buf.size() - 1);
      line_buf[n] = non_hex_char();
      if ($urandom_range(1)) line_buf[$urandom_range(1, line_buf.size() - 1)] = non_hex_char();
    end else if (r < 85) begin
      line_buf[last_idlen + 1] = $urandom_range(2) == 0 ? non_hex_char() :
                                 hex_char($urandom_range(MAX_BYTES + 1, 15));
    end else if (r < 90) begin
      do begin
        line_buf.delete();
        line_buf.push_back(any_but_cr());
      end while (line_buf[0] == CH_STD_DATA || line_buf[0] == CH_EXT_DATA ||
                 line_buf[0] == CH_STD_RTR || line_buf[0] == CH_EXT_RTR);
      repeat ($urandom_range(0, 12)) line_buf.push_back(hex_char($urandom_range(15)));
    end else begin
      line_buf.delete();
      repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(255)));
    end
    flush_line();
  endtask

  task automatic fill_chars(input int target);
    int start;
    start = chars_queued;
    while (chars_queued - start < target) add_line();
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (char_q.size() != 0 || rx_ch.valid || frames_due.size() != 0);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    send_idle_pct <= idle_pct;
    recv_stall_pct <= stall_pct;
    fill_chars(PHASE_CHARS);
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    hold_tog = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    chars_queued = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty line, bad command, dlc above range, extended remote, bad id digit
    push_text("");
    push_text("q");
    push_text("t0009");
    push_text("R1fFfFfFf8");
    push_text("t1g3");
    wait_drained();

    run_phase(0, 0);
    run_phase(81, 0);
    run_phase(0, 81);
    run_phase(25, 25);

    // sink holds off while characters keep coming
    send_idle_pct <= 0;
    recv_stall_pct <= 0;
    hold_tog <= ~hold_tog;
    fill_chars(250);
    wait_drained();

    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("slcan_ascii_frame_decoder_core_tb: PASS");
    end else begin
      $display("slcan_ascii_frame_decoder_core_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ slcan_ascii_frame_decoder_core.f @@
hdl/slcan_pkg.sv
hdl/slcan_ifs.sv
hdl/slcan_front.sv
hdl/slcan_queue.sv
hdl/slcan_back.sv
hdl/slcan_ascii_frame_decoder_core.sv
hdl/slcan_chk.sv
bench/slcan_ascii_frame_decoder_core_tb.sv
